@@ src/rbt_pkg.sv @@
// ----------------------------------------------------------------------------
// rbt_pkg
// Shared constants, types and the exp2 table for the Boltzmann term block.
// ----------------------------------------------------------------------------
package rbt_pkg;

  localparam int ENERGY_BITS     = 24;
  localparam int J_BITS          = 8;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);
  localparam int COEF_BITS       = 32;
  localparam int QEVJ_BITS       = 57;
  localparam int CFG_IDX_BITS    = 3;
  localparam int TAB_BITS        = 31;
  localparam int FRAC_BITS       = 28 - EXP_IDX_BITS;

  localparam logic [63:0] LN2_Q60   = 64'h0B17217F7D1CF79B;
  localparam logic [28:0] LOG2E_Q28 = 29'h17154765;

  // arguments above 64 in Q.36 underflow to zero
  localparam logic [57:0] ARG_LIMIT = 58'd64 << 36;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_E = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_V = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_R = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_EVEN_W = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ODD_W  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BASE_W = 3'd5;

  // classified level passed from front to back
  typedef struct packed {
    logic [J_BITS-1:0]      rot_j;
    logic [ENERGY_BITS-1:0] term_energy;
    logic [ENERGY_BITS-1:0] vib_base;
    logic [ENERGY_BITS-1:0] rot_mag;
    logic                   rot_neg;
  } level_t;

  typedef struct packed {
    logic [COEF_BITS-1:0] coef_e;
    logic [COEF_BITS-1:0] coef_v;
    logic [COEF_BITS-1:0] coef_r;
    logic [7:0]           even_w;
    logic [7:0]           odd_w;
    logic [15:0]          base_w;
  } cfg_t;

  typedef logic [TAB_BITS-1:0] pow2_tab_t [0:EXP_TABLE_DEPTH];

  // 2^(-i/depth) in Q1.30 from a series for exp(-t) in Q.60
  function automatic pow2_tab_t build_pow2_tab();
    pow2_tab_t   tab;
    logic [63:0] q;
    logic [63:0] rm;
    logic [63:0] t;
    logic [63:0] plus;
    logic [63:0] minus;
    logic [63:0] term;
    logic [63:0] val;
    logic [127:0] prod;
    q  = LN2_Q60 / EXP_TABLE_DEPTH;
    rm = LN2_Q60 % EXP_TABLE_DEPTH;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      t     = q * 64'(i) + (rm * 64'(i)) / EXP_TABLE_DEPTH;
      plus  = 64'd1 << 60;
      minus = 64'd0;
      term  = 64'd1 << 60;
      for (int k = 1; k <= 24; k++) begin
        prod = {64'd0, term} * {64'd0, t};
        term = prod[123:60] / 64'(k);
        if ((k % 2) == 1) begin
          minus = minus + term;
        end else begin
          plus = plus + term;
        end
      end
      val    = (plus > minus) ? plus - minus : 64'd0;
      tab[i] = TAB_BITS'((val + (64'd1 << 29)) >> 30);
    end
    return tab;
  endfunction

  localparam pow2_tab_t POW2_TAB = build_pow2_tab();

endpackage

@@ src/rbt_ifs.sv @@
// ----------------------------------------------------------------------------
// rbt_ifs
// Valid/ready channels: level input, term output and register writes.
// ----------------------------------------------------------------------------
interface rbt_in_if
  import rbt_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [J_BITS-1:0]      rot_j;
  logic [ENERGY_BITS-1:0] level_energy;
  logic [ENERGY_BITS-1:0] term_energy;
  modport source (output valid, rot_j, level_energy, term_energy, input ready);
  modport sink (input valid, rot_j, level_energy, term_energy, output ready);
endinterface

interface rbt_out_if
  import rbt_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [QEVJ_BITS-1:0] qevj;
  modport source (output valid, qevj, input ready);
  modport sink (input valid, qevj, output ready);
endinterface

interface rbt_cfg_if
  import rbt_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COEF_BITS-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ src/rovibronic_boltzmann_term.sv @@
// ----------------------------------------------------------------------------
// rovibronic_boltzmann_term
// Weighted Boltzmann term of one rovibronic level per request.
// ----------------------------------------------------------------------------
// Channels: in_ch carries one level (rot_j, level_energy, term_energy) per
// request; out_ch returns one qevj per request in the same order; cfg writes
// the six coefficient and weight registers by index, always ready, and is
// meant to be used only while no request is in flight.
// A request with rot_j zero latches its level energy as the vibrational base.
// The back-end sequencer steps through pop, three coefficient multiplies,
// argument sum, log2 scaling, table lookup, interpolation, weight multiply
// and output load for each request, and pops no new request until it is
// back in idle after the output load.
// A two-entry queue lets the front accept requests while the back works; when
// the receiver stalls the result holds in the output register, the back
// waits at its last step and the queue fills before in_ch drops ready.
// Reset clears the base, the queue and the output valid flag, and restores the
// register defaults.
// ----------------------------------------------------------------------------
module rovibronic_boltzmann_term
  import rbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  rbt_in_if.sink     in_ch,
  rbt_out_if.source  out_ch,
  rbt_cfg_if.sink    cfg
);

  cfg_t   regs;
  logic   push;
  logic   push_ready;
  level_t push_item;
  logic   pop_valid;
  logic   pop;
  level_t pop_item;

  assign cfg.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.coef_e <= '0;
      regs.coef_v <= '0;
      regs.coef_r <= '0;
      regs.even_w <= 8'd1;
      regs.odd_w  <= 8'd1;
      regs.base_w <= 16'd256;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_COEF_E: regs.coef_e <= cfg.data;
        REG_COEF_V: regs.coef_v <= cfg.data;
        REG_COEF_R: regs.coef_r <= cfg.data;
        REG_EVEN_W: regs.even_w <= cfg.data[7:0];
        REG_ODD_W:  regs.odd_w  <= cfg.data[7:0];
        REG_BASE_W: regs.base_w <= cfg.data[15:0];
        default: ;
      endcase
    end
  end

  rbt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  rbt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_item   (pop_item)
  );

  rbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (regs),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_item  (pop_item),
    .out_ch    (out_ch)
  );

endmodule

@@ src/rbt_front.sv @@
// ----------------------------------------------------------------------------
// rbt_front
// Accepts levels, tracks the vibrational base and splits off the rotational part.
// ----------------------------------------------------------------------------
module rbt_front
  import rbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  rbt_in_if.sink in_ch,
  output logic   push,
  input  logic   push_ready,
  output level_t push_item
);

  logic [ENERGY_BITS-1:0] vib_base;
  logic [ENERGY_BITS-1:0] base_now;

  assign in_ch.ready = push_ready;
  assign push        = in_ch.valid && push_ready;

  // a zero rotational number opens a new band
  assign base_now = (in_ch.rot_j == '0) ? in_ch.level_energy : vib_base;

  always_comb begin
    push_item.rot_j       = in_ch.rot_j;
    push_item.term_energy = in_ch.term_energy;
    push_item.vib_base    = base_now;
    push_item.rot_neg     = in_ch.level_energy < base_now;
    push_item.rot_mag     = push_item.rot_neg ? base_now - in_ch.level_energy
                                              : in_ch.level_energy - base_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vib_base <= '0;
    end else if (push) begin
      vib_base <= base_now;
    end
  end

endmodule

@@ src/rbt_queue.sv @@
// ----------------------------------------------------------------------------
// rbt_queue
// Two-entry queue between front and back.
// ----------------------------------------------------------------------------
module rbt_queue
  import rbt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   push_ready,
  input  level_t push_item,
  output logic   pop_valid,
  input  logic   pop,
  output level_t pop_item
);

  level_t     slots [0:1];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_item   = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ src/rbt_back.sv @@
// ----------------------------------------------------------------------------
// rbt_back
// Sequencer for argument, exp2 interpolation, weighting and output register.
// ----------------------------------------------------------------------------
module rbt_back
  import rbt_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  cfg_t           cfg,
  input  logic           pop_valid,
  output logic           pop,
  input  level_t         pop_item,
  rbt_out_if.source      out_ch
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MUL_E  = 10'b0000000010,
    S_MUL_V  = 10'b0000000100,
    S_MUL_R  = 10'b0000001000,
    S_SUM    = 10'b0000010000,
    S_LOG    = 10'b0000100000,
    S_LOOK   = 10'b0001000000,
    S_INTERP = 10'b0010000000,
    S_WMUL   = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t                 state;
  level_t                 item;
  logic [57:0]            acc;
  logic [55:0]            rot_prod;
  logic [57:0]            arg;
  logic                   big;
  logic [36:0]            y;
  logic [TAB_BITS-1:0]    tab_a;
  logic [TAB_BITS-1:0]    tab_b;
  logic [27:0]            frac_r;
  logic [TAB_BITS-1:0]    mant;
  logic [23:0]            w1;
  logic [32:0]            w2;
  logic [63:0]            prod;
  logic [QEVJ_BITS-1:0]   qevj;
  logic                   out_valid;

  logic [COEF_BITS-1:0]   mul_c;
  logic [ENERGY_BITS-1:0] mul_e;
  logic [55:0]            mul_p;
  logic [64:0]            y_full;
  logic [EXP_IDX_BITS-1:0] idx;
  logic [EXP_IDX_BITS:0]  idx_next;
  logic [TAB_BITS-1:0]    diff;
  logic [58:0]            interp;
  logic [8:0]             yi;
  logic [9:0]             sh;
  logic [63:0]            shifted;
  logic                   out_free;

  assign pop          = (state == S_IDLE) && pop_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.qevj  = qevj;
  assign out_free     = !out_valid || out_ch.ready;

  // shared coefficient multiplier
  always_comb begin
    unique case (state)
      S_MUL_E: begin
        mul_c = cfg.coef_e;
        mul_e = item.term_energy;
      end
      S_MUL_V: begin
        mul_c = cfg.coef_v;
        mul_e = item.vib_base;
      end
      default: begin
        mul_c = cfg.coef_r;
        mul_e = item.rot_mag;
      end
    endcase
  end

  assign mul_p = mul_c * mul_e;

  // datapath helpers
  assign y_full   = {29'd0, arg[43:8]} * {36'd0, LOG2E_Q28};
  assign idx      = y[27:28-EXP_IDX_BITS];
  assign idx_next = {1'b0, idx} + 1'b1;
  assign diff     = (tab_a > tab_b) ? tab_a - tab_b : '0;
  assign interp   = {28'd0, diff} * {31'd0, frac_r};
  assign yi       = y[36:28];
  assign sh       = {1'b0, yi} + 10'd6;
  assign shifted  = prod >> sh[5:0];

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            item  <= pop_item;
            state <= S_MUL_E;
          end
        end
        S_MUL_E: begin
          acc   <= {2'd0, mul_p};
          w1    <= (item.rot_j[0] ? cfg.odd_w : cfg.even_w) * cfg.base_w;
          state <= S_MUL_V;
        end
        S_MUL_V: begin
          acc   <= acc + {2'd0, mul_p};
          w2    <= w1 * {item.rot_j, 1'b1};
          state <= S_MUL_R;
        end
        S_MUL_R: begin
          rot_prod <= mul_p;
          state    <= S_SUM;
        end
        S_SUM: begin
          if (!item.rot_neg) begin
            arg <= acc + {2'd0, rot_prod};
          end else if (acc > {2'd0, rot_prod}) begin
            arg <= acc - {2'd0, rot_prod};
          end else begin
            arg <= '0;
          end
          state <= S_LOG;
        end
        S_LOG: begin
          big   <= arg > ARG_LIMIT;
          y     <= y_full[64:28];
          state <= S_LOOK;
        end
        S_LOOK: begin
          tab_a  <= POW2_TAB[idx];
          tab_b  <= POW2_TAB[idx_next];
          frac_r <= {y[FRAC_BITS-1:0], EXP_IDX_BITS'(0)};
          state  <= S_INTERP;
        end
        S_INTERP: begin
          mant  <= tab_a - interp[58:28];
          state <= S_WMUL;
        end
        S_WMUL: begin
          prod  <= w2 * mant;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            // underflow, full shift-out and saturation
            if (big || sh >= 10'd64) begin
              qevj <= '0;
            end else if (shifted[63:QEVJ_BITS] != '0) begin
              qevj <= '1;
            end else begin
              qevj <= shifted[QEVJ_BITS-1:0];
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/rovibronic_boltzmann_term_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rovibronic_boltzmann_term_tb
// Self-checking bench: directed levels from a table, then random vibrational
// bands under several register settings, checked against a bit-true predictor.
// ----------------------------------------------------------------------------
module rovibronic_boltzmann_term_tb;
  import rbt_pkg::*;

  localparam int          DRAIN_CYCLES = 16;
  localparam int          WDOG_LIMIT   = 5000;
  localparam int          HOLD_CYCLES  = 300;
  localparam logic [56:0] QEVJ_MAX     = {57{1'b1}};

  logic clk;
  logic rst;

  rbt_in_if  in_ch ();
  rbt_out_if out_ch ();
  rbt_cfg_if cfg ();

  rovibronic_boltzmann_term uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg    (cfg.sink)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // predictor state
  logic [30:0]            exp2_lut [0:EXP_TABLE_DEPTH];
  logic [31:0]            m_coef_e;
  logic [31:0]            m_coef_v;
  logic [31:0]            m_coef_r;
  logic [7:0]             m_even_w;
  logic [7:0]             m_odd_w;
  logic [15:0]            m_base_w;
  logic [ENERGY_BITS-1:0] m_vib_base;

  logic [56:0] qevj_pending[$];
  int          errors;
  int          levels_sent;
  int          terms_seen;
  int          zero_terms;
  int          sat_terms;
  int          idle_cycles;
  bit          calm;
  bit          hold_req;
  bit          hold_done;
  int          hold_cnt;

  // 2^(-i/depth) in Q1.30 via alternating series
  task automatic fill_exp2_lut();
    logic [63:0]  q, rm, t, plus, minus, term, val;
    logic [127:0] prod;
    q  = LN2_Q60 / EXP_TABLE_DEPTH;
    rm = LN2_Q60 % EXP_TABLE_DEPTH;
    for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
      t     = q * 64'(i) + (rm * 64'(i)) / EXP_TABLE_DEPTH;
      plus  = 64'd1 << 60;
      minus = 64'd0;
      term  = 64'd1 << 60;
      for (int k = 1; k <= 24; k++) begin
        prod = 128'(term) * 128'(t);
        term = prod[123:60] / 64'(k);
        if (k % 2 == 1) begin
          minus = minus + term;
        end else begin
          plus = plus + term;
        end
      end
      val = (plus > minus) ? plus - minus : 64'd0;
      exp2_lut[i] = 31'((val + (64'd1 << 29)) >> 30);
    end
  endtask

  // weighted boltzmann term of one level; updates the vibrational base
  function automatic logic [56:0] boltzmann_term(logic [7:0] j, logic [23:0] le,
                                                 logic [23:0] te);
    logic [65:0]  pos, neg, x;
    logic [63:0]  y, s, r, a, b, m;
    logic [35:0]  yi;
    logic [8:0]   idx;
    logic [7:0]   gn;
    logic [127:0] w, prod, res;
    if (j == 0) m_vib_base = le;
    pos = 66'(m_coef_e) * te + 66'(m_coef_v) * m_vib_base;
    neg = 66'd0;
    if (le >= m_vib_base) begin
      pos = pos + 66'(m_coef_r) * (le - m_vib_base);
    end else begin
      neg = 66'(m_coef_r) * (m_vib_base - le);
    end
    if (pos > 66'hFFFF_FFFF_FFFF_FFFF) pos = 66'hFFFF_FFFF_FFFF_FFFF;
    x = (pos > neg) ? pos - neg : 66'd0;
    if (x > (66'd64 << 36)) return 57'd0;
    y   = ((x[63:0] >> 8) * 64'(LOG2E_Q28)) >> 28;
    yi  = 36'(y >> 28);
    s   = (y & 64'hFFF_FFFF) * EXP_TABLE_DEPTH;
    idx = 9'(s >> 28);
    if (idx >= EXP_TABLE_DEPTH) idx = 9'(EXP_TABLE_DEPTH - 1);
    r = s & 64'hFFF_FFFF;
    a = 64'(exp2_lut[idx]);
    b = 64'(exp2_lut[idx + 1]);
    m = a - ((a > b) ? ((a - b) * r) >> 28 : 64'd0);
    gn   = j[0] ? m_odd_w : m_even_w;
    w    = 128'(gn) * m_base_w * (2 * 128'(j) + 1);
    prod = w * m;
    res  = (6 + yi >= 128) ? 128'd0 : prod >> (6 + yi);
    return (res > QEVJ_MAX) ? QEVJ_MAX : res[56:0];
  endfunction

  // one level request; literal expectation used when lit is set
  task automatic send_level(logic [7:0] j, logic [23:0] le, logic [23:0] te,
                            bit lit = 0, logic [56:0] lit_val = '0);
    logic [56:0] pred;
    if (!calm) begin
      while ($urandom_range(99) < 37) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    pred = boltzmann_term(j, le, te);
    in_ch.valid        <= 1'b1;
    in_ch.rot_j        <= j;
    in_ch.level_energy <= le;
    in_ch.term_energy  <= te;
    do @(posedge clk); while (!in_ch.ready);
    qevj_pending.push_back(lit ? lit_val : pred);
    levels_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (qevj_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      REG_COEF_E: m_coef_e = data;
      REG_COEF_V: m_coef_v = data;
      REG_COEF_R: m_coef_r = data;
      REG_EVEN_W: m_even_w = data[7:0];
      REG_ODD_W:  m_odd_w  = data[7:0];
      REG_BASE_W: m_base_w = data[15:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [31:0] ce, logic [31:0] cv, logic [31:0] cr,
                           logic [7:0] ew, logic [7:0] ow, logic [15:0] bw);
    wait_idle();
    write_reg(REG_COEF_E, ce);
    write_reg(REG_COEF_V, cv);
    write_reg(REG_COEF_R, cr);
    write_reg(REG_EVEN_W, {24'd0, ew});
    write_reg(REG_ODD_W, {24'd0, ow});
    write_reg(REG_BASE_W, {16'd0, bw});
  endtask

  function automatic logic [31:0] rand_coef();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 32'hFFFF_FFFF;
    if (pick == 1) return 32'd0;
    return $urandom >> $urandom_range(12, 31);
  endfunction

  function automatic logic [7:0] rand_w8();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'hFF;
    return 8'($urandom_range(1, 9));
  endfunction

  // directed levels
  typedef struct {
    logic [7:0]  j;
    logic [23:0] le;
    logic [23:0] te;
    bit          lit;
    logic [56:0] val;
  } level_row_t;

  level_row_t dir_rows[] = '{
    '{8'd0,   24'd0,        24'd0,        1, 57'h1_0000_0000},
    '{8'd1,   24'hFF_FFFF,  24'hFF_FFFF,  1, 57'h3_0000_0000},
    '{8'd255, 24'h12_3456,  24'd0,        1, 57'h1FF_0000_0000},
    '{8'd0,   24'hFF_FFFF,  24'hFF_FFFF,  1, 57'h1_0000_0000},
    '{8'd2,   24'd0,        24'h00_0001,  1, 57'h5_0000_0000},
    '{8'd254, 24'hAA_AAAA,  24'h55_5555,  1, 57'h1FD_0000_0000}
  };

  level_row_t band_rows[] = '{
    '{8'd0,   24'h00_1000,  24'h00_0100,  0, '0},
    '{8'd1,   24'h00_1020,  24'h00_0100,  0, '0},
    '{8'd2,   24'h00_0F00,  24'h00_0100,  0, '0},
    '{8'd3,   24'h00_0000,  24'h00_0000,  0, '0},
    '{8'd4,   24'hFF_FFFF,  24'h00_0000,  0, '0},
    '{8'd0,   24'h00_0000,  24'h00_0000,  0, '0},
    '{8'd255, 24'h00_8000,  24'h00_2000,  0, '0},
    '{8'd128, 24'h00_0400,  24'hFF_FFFF,  0, '0}
  };

  task automatic run_rows(level_row_t rows[]);
    foreach (rows[i]) send_level(rows[i].j, rows[i].le, rows[i].te, rows[i].lit, rows[i].val);
  endtask

  // random vibrational bands with some noise
  task automatic random_phase(int n);
    logic [23:0] base, le, step;
    int          k, len, sh;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) < 8) begin
        len  = $urandom_range(1, 20);
        sh   = $urandom_range(0, 8);
        base = 24'($urandom >> (8 + sh));
        step = 24'($urandom_range(1, 64));
        for (int jj = 0; jj < len && k < n; jj++) begin
          le = base + 24'(jj * (jj + 1)) * step;
          if ($urandom_range(9) == 0) le = base - 24'($urandom_range(0, 4096));
          calm = (levels_sent >= 500 && levels_sent < 650);
          send_level(8'(jj), le, 24'($urandom >> (8 + sh)));
          k++;
        end
      end else begin
        calm = (levels_sent >= 500 && levels_sent < 650);
        send_level(8'($urandom), 24'($urandom), 24'($urandom));
        k++;
      end
      if (levels_sent >= 300) hold_req = 1;
    end
  endtask

  // receiver: random idling plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_cnt     <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done    <= 1'b1;
      hold_cnt     <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 37);
    end
  end

  // result checker
  always @(posedge clk) begin
    logic [56:0] exp_q;
    if (!rst && out_ch.valid && out_ch.ready) begin
      terms_seen++;
      if (out_ch.qevj == 0) zero_terms++;
      if (out_ch.qevj == QEVJ_MAX) sat_terms++;
      if (qevj_pending.size() == 0) begin
        $display("%0t: unexpected qevj %h", $time, out_ch.qevj);
        errors++;
      end else begin
        exp_q = qevj_pending.pop_front();
        if (out_ch.qevj !== exp_q) begin
          $display("%0t: qevj mismatch expected %h actual %h", $time, exp_q, out_ch.qevj);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d terms pending", $time, qevj_pending.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    errors = 0; levels_sent = 0; terms_seen = 0; zero_terms = 0; sat_terms = 0;
    idle_cycles = 0; calm = 0; hold_req = 0; hold_done = 0;
    in_ch.valid = 1'b0; in_ch.rot_j = '0; in_ch.level_energy = '0; in_ch.term_energy = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    m_coef_e = 32'd0; m_coef_v = 32'd0; m_coef_r = 32'd0;
    m_even_w = 8'd1; m_odd_w = 8'd1; m_base_w = 16'd256; m_vib_base = '0;
    fill_exp2_lut();
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: unit factor, weight (2j+1)
    run_rows(dir_rows);
    // largest weights, just below full scale
    write_all(32'd0, 32'd0, 32'd0, 8'hFF, 8'hFF, 16'hFFFF);
    send_level(8'd255, 24'd0, 24'd0, 1, 57'h1FC_FF02_FF00_0000);
    send_level(8'd1, 24'd0, 24'd0);
    // huge argument underflows to zero
    write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd3, 8'd1, 16'h0100);
    send_level(8'd0, 24'hFF_FFFF, 24'hFF_FFFF, 1, 57'd0);
    send_level(8'd5, 24'd0, 24'd0);
    // zero even weight, moderate coefficients, level below base
    write_all(32'h0000_4000, 32'h0000_2000, 32'h0001_0000, 8'd0, 8'd3, 16'h0080);
    run_rows(band_rows);
    write_all(32'h0000_0100, 32'h0000_0800, 32'h0000_1000, 8'd2, 8'd0, 16'd0);
    run_rows(band_rows);

    for (int p = 0; p < 6; p++) begin
      write_all(rand_coef(), rand_coef(), rand_coef(), rand_w8(), rand_w8(),
                ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom));
      random_phase(150);
    end

    wait_idle();
    $display("sent %0d levels over 11 register settings, %0d terms checked",
             levels_sent, terms_seen);
    $display("zero terms %0d, saturated terms %0d, mismatches %0d",
             zero_terms, sat_terms, errors);
    if (errors == 0 && qevj_pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/rbt_pkg.sv
src/rbt_ifs.sv
src/rbt_front.sv
src/rbt_queue.sv
src/rbt_back.sv
src/rovibronic_boltzmann_term.sv
tb/sv/rovibronic_boltzmann_term_tb.sv
